// ----- rtl/mrc_pkg.sv -----
package mrc_pkg;

   localparam int MAX_TUPLES     = 1024;
   localparam int MAX_PASSES     = 4;
   localparam int MAX_DIGIT_BITS = 8;
   localparam int CLUSTERS       = 1 << MAX_DIGIT_BITS;
   localparam int TIDX_W         = $clog2(MAX_TUPLES);
   localparam int CNT_W          = $clog2(MAX_TUPLES + 1);
   localparam int DIG_W          = MAX_DIGIT_BITS;
   localparam int PASS_W         = $clog2(MAX_PASSES) > 0 ? $clog2(MAX_PASSES) : 1;
   localparam int NCL_W          = MAX_DIGIT_BITS + 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;

   localparam logic [2:0] CSR_PASS_COUNT  = 3'd0;
   localparam logic [2:0] CSR_KEY_BITS    = 3'd1;
   localparam logic [2:0] CSR_PASS_BITS_0 = 3'd2;
   localparam logic [2:0] CSR_PASS_BITS_1 = 3'd3;
   localparam logic [2:0] CSR_PASS_BITS_2 = 3'd4;
   localparam logic [2:0] CSR_PASS_BITS_3 = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [31:0] tuple_value;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] out_value;
      logic [10:0] out_position;
      logic        out_last;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [3:0] clamp_bits(input logic [3:0] b);
      logic [3:0] r;
      r = (b > 4'(MAX_DIGIT_BITS)) ? 4'(MAX_DIGIT_BITS) : b;
      return r;
   endfunction

   // Start bit of the digit of pass p: key_bits less the widths of passes 0..p,
   // saturating at zero.
   function automatic logic [5:0] pass_shift(input logic [5:0] key_bits,
                                             input logic [3:0] b0, input logic [3:0] b1,
                                             input logic [3:0] b2, input logic [3:0] b3,
                                             input logic [1:0] p);
      logic [5:0] low;
      logic [3:0] w [4];
      low  = key_bits;
      w[0] = clamp_bits(b0);
      w[1] = clamp_bits(b1);
      w[2] = clamp_bits(b2);
      w[3] = clamp_bits(b3);
      for (int q = 0; q < 4; q++) begin
         if (2'(q) <= p) begin
            low = (low > 6'(w[q])) ? low - 6'(w[q]) : 6'd0;
         end
      end
      return low;
   endfunction

   function automatic logic [DIG_W-1:0] digit_of(input logic [31:0] v,
                                                 input logic [5:0] shift,
                                                 input logic [3:0] w);
      logic [31:0] s;
      logic [NCL_W-1:0] m;
      s = v >> shift[4:0];
      m = (NCL_W'(1) << w) - NCL_W'(1);
      return shift[5] ? '0 : (s[DIG_W-1:0] & m[DIG_W-1:0]);
   endfunction

endpackage

// ----- rtl/multipass_radix_clustering.sv -----
// Multi-pass radix clustering of 32-bit tuples.
// Input channel req_*: one item per transfer. A load (opcode 0) stores a tuple
// and answers with the count loaded so far; a load with is_last set starts
// clustering. A read (opcode 1) returns the next clustered tuple with its
// position, or status "nothing to read".
// Result channel rsp_*: exactly one result per item, held in an output
// register until its transfer; while it waits, req_stall stays high.
// A load or a failed read answers in the cycle after its transfer; a good read
// goes through S_RD_WAIT first, as the tuple memory has registered reads.
// One item at a time: the next is not taken until the last result has gone.
// Clustering after the last load runs one counting sort per pass on a single
// memory port set: it clears the 2^w counters, counts each tuple (S_CNT_*),
// forms the prefix sum per cluster (S_PRE_*) and scatters each tuple
// (S_SC_*); the block is stalled then.
// Passes ping-pong between two tuple memories; no copy pass is needed.
// Reset (synchronous, active high) restores the register defaults and starts
// an empty batch; memories are not cleared and need no clearing pass.
// Configuration is written through csr_we/csr_index/csr_wdata while idle.
module multipass_radix_clustering (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mrc_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mrc_pkg::rsp_type        rsp_data,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [5:0]              csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_WAIT, S_CLR, S_CNT_RD, S_CNT_DIG, S_CNT_WR,
      S_PRE_RD, S_PRE_WR, S_SC_RD, S_SC_DIG, S_SC_WR
   } state_type;

   state_type                   state_ff;
   logic [2:0]                  pass_count_ff;
   logic [5:0]                  key_bits_ff;
   logic [3:0]                  pbits_ff [4];
   logic [mrc_pkg::CNT_W-1:0]   loaded_ff;
   logic [mrc_pkg::CNT_W-1:0]   rptr_ff;
   logic                        reading_ff;
   logic                        cur_sel_ff;
   logic [mrc_pkg::PASS_W-1:0]  pass_ff;
   logic [mrc_pkg::CNT_W-1:0]   idx_ff;
   logic [mrc_pkg::CNT_W-1:0]   run_ff;
   logic [31:0]                 tup_ff;
   logic [mrc_pkg::DIG_W-1:0]   dig_ff;
   logic                        rsp_valid_ff;
   mrc_pkg::rsp_type            rsp_ff;

   logic                        src_we, dst_we, cnt_we;
   logic [mrc_pkg::TIDX_W-1:0]  src_waddr, src_raddr, dst_waddr;
   logic [31:0]                 src_wdata, dst_wdata;
   logic [mrc_pkg::DIG_W-1:0]   cnt_waddr, cnt_raddr;
   logic [mrc_pkg::CNT_W-1:0]   cnt_wdata, cnt_rdata;
   logic [31:0]                 a_rdata, b_rdata, src_rdata;

   logic                        accept;
   logic [3:0]                  cur_w;
   logic [5:0]                  cur_shift;
   logic [mrc_pkg::NCL_W-1:0]   cur_ncl;
   logic [mrc_pkg::DIG_W-1:0]   cur_dig;
   logic [mrc_pkg::CNT_W-1:0]   load_base;
   logic [2:0]                  np;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cur_w     = mrc_pkg::clamp_bits(pbits_ff[pass_ff]);
   assign cur_shift = mrc_pkg::pass_shift(key_bits_ff, pbits_ff[0], pbits_ff[1],
                                          pbits_ff[2], pbits_ff[3], 2'(pass_ff));
   assign cur_ncl   = mrc_pkg::NCL_W'(1) << cur_w;
   assign cur_dig   = mrc_pkg::digit_of(src_rdata, cur_shift, cur_w);
   assign load_base = reading_ff ? '0 : loaded_ff;
   assign np        = (pass_count_ff == 3'd0) ? 3'd1 :
                      (pass_count_ff > 3'(mrc_pkg::MAX_PASSES)) ?
                      3'(mrc_pkg::MAX_PASSES) : pass_count_ff;
   assign src_rdata = cur_sel_ff ? b_rdata : a_rdata;

   always_comb begin
      src_we    = 1'b0;
      src_waddr = load_base[mrc_pkg::TIDX_W-1:0];
      src_wdata = req_data.tuple_value;
      src_raddr = idx_ff[mrc_pkg::TIDX_W-1:0];
      dst_we    = 1'b0;
      dst_waddr = cnt_rdata[mrc_pkg::TIDX_W-1:0];
      dst_wdata = tup_ff;
      cnt_we    = 1'b0;
      cnt_waddr = dig_ff;
      cnt_wdata = cnt_rdata + mrc_pkg::CNT_W'(1);
      cnt_raddr = cur_dig;
      case (state_ff)
         S_IDLE: begin
            src_raddr = rptr_ff[mrc_pkg::TIDX_W-1:0];
            src_we    = accept && (req_data.opcode == mrc_pkg::OP_LOAD) &&
                        (load_base < mrc_pkg::CNT_W'(mrc_pkg::MAX_TUPLES));
         end
         S_CLR: begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff[mrc_pkg::DIG_W-1:0];
            cnt_wdata = '0;
         end
         S_CNT_WR: cnt_we = 1'b1;
         S_PRE_RD: cnt_raddr = idx_ff[mrc_pkg::DIG_W-1:0];
         S_PRE_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff[mrc_pkg::DIG_W-1:0];
            cnt_wdata = run_ff;
         end
         S_SC_WR: begin
            cnt_we = 1'b1;
            dst_we = 1'b1;
         end
         default: ;
      endcase
   end

   mrc_ram #(.WIDTH(32), .DEPTH(mrc_pkg::MAX_TUPLES)) u_ram_a (
      .clock (clock),
      .we    (cur_sel_ff ? dst_we : src_we),
      .waddr (cur_sel_ff ? dst_waddr : src_waddr),
      .wdata (cur_sel_ff ? dst_wdata : src_wdata),
      .raddr (src_raddr),
      .rdata (a_rdata)
   );

   mrc_ram #(.WIDTH(32), .DEPTH(mrc_pkg::MAX_TUPLES)) u_ram_b (
      .clock (clock),
      .we    (cur_sel_ff ? src_we : dst_we),
      .waddr (cur_sel_ff ? src_waddr : dst_waddr),
      .wdata (cur_sel_ff ? src_wdata : dst_wdata),
      .raddr (src_raddr),
      .rdata (b_rdata)
   );

   mrc_ram #(.WIDTH(mrc_pkg::CNT_W), .DEPTH(mrc_pkg::CLUSTERS)) u_ram_cnt (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pass_count_ff <= 3'd1;
         key_bits_ff   <= 6'd8;
         pbits_ff[0]   <= 4'd8;
         pbits_ff[1]   <= 4'd1;
         pbits_ff[2]   <= 4'd1;
         pbits_ff[3]   <= 4'd1;
         loaded_ff     <= '0;
         rptr_ff       <= '0;
         reading_ff    <= 1'b0;
         cur_sel_ff    <= 1'b0;
         pass_ff       <= '0;
         idx_ff        <= '0;
         run_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mrc_pkg::CSR_PASS_COUNT:  pass_count_ff <= csr_wdata[2:0];
               mrc_pkg::CSR_KEY_BITS:    key_bits_ff   <= csr_wdata;
               mrc_pkg::CSR_PASS_BITS_0: pbits_ff[0]   <= csr_wdata[3:0];
               mrc_pkg::CSR_PASS_BITS_1: pbits_ff[1]   <= csr_wdata[3:0];
               mrc_pkg::CSR_PASS_BITS_2: pbits_ff[2]   <= csr_wdata[3:0];
               mrc_pkg::CSR_PASS_BITS_3: pbits_ff[3]   <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_data.opcode == mrc_pkg::OP_LOAD) begin
                     rptr_ff      <= '0;
                     rsp_valid_ff <= 1'b1;
                     if (load_base < mrc_pkg::CNT_W'(mrc_pkg::MAX_TUPLES)) begin
                        loaded_ff <= load_base + mrc_pkg::CNT_W'(1);
                        rsp_ff    <= '{out_value: 32'd0,
                                       out_position: 11'(load_base + mrc_pkg::CNT_W'(1)),
                                       out_last: 1'b0, status: mrc_pkg::ST_OK};
                     end else begin
                        loaded_ff <= load_base;
                        rsp_ff    <= '{out_value: 32'd0, out_position: 11'(load_base),
                                       out_last: 1'b0, status: mrc_pkg::ST_DROPPED};
                     end
                     reading_ff <= 1'b0;
                     if (req_data.is_last) begin
                        pass_ff  <= mrc_pkg::PASS_W'(np - 3'd1);
                        idx_ff   <= '0;
                        state_ff <= S_CLR;
                     end
                  end else if (reading_ff && (rptr_ff < loaded_ff)) begin
                     state_ff <= S_RD_WAIT;
                  end else begin
                     rsp_ff       <= '{out_value: 32'd0, out_position: 11'd0,
                                       out_last: 1'b0, status: mrc_pkg::ST_EMPTY};
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_RD_WAIT: begin
               rsp_ff       <= '{out_value: src_rdata, out_position: 11'(rptr_ff),
                                 out_last: ((rptr_ff + mrc_pkg::CNT_W'(1)) == loaded_ff),
                                 status: mrc_pkg::ST_OK};
               rsp_valid_ff <= 1'b1;
               rptr_ff      <= rptr_ff + mrc_pkg::CNT_W'(1);
               state_ff     <= S_IDLE;
            end
            S_CLR: begin
               if (idx_ff == mrc_pkg::CNT_W'(cur_ncl - mrc_pkg::NCL_W'(1))) begin
                  idx_ff   <= '0;
                  state_ff <= S_CNT_RD;
               end else begin
                  idx_ff <= idx_ff + mrc_pkg::CNT_W'(1);
               end
            end
            S_CNT_RD: state_ff <= S_CNT_DIG;
            S_CNT_DIG: begin
               dig_ff   <= cur_dig;
               state_ff <= S_CNT_WR;
            end
            S_CNT_WR: begin
               if (idx_ff == loaded_ff - mrc_pkg::CNT_W'(1)) begin
                  idx_ff   <= '0;
                  run_ff   <= '0;
                  state_ff <= S_PRE_RD;
               end else begin
                  idx_ff   <= idx_ff + mrc_pkg::CNT_W'(1);
                  state_ff <= S_CNT_RD;
               end
            end
            S_PRE_RD: state_ff <= S_PRE_WR;
            S_PRE_WR: begin
               run_ff <= run_ff + cnt_rdata;
               if (idx_ff == mrc_pkg::CNT_W'(cur_ncl - mrc_pkg::NCL_W'(1))) begin
                  idx_ff   <= '0;
                  state_ff <= S_SC_RD;
               end else begin
                  idx_ff   <= idx_ff + mrc_pkg::CNT_W'(1);
                  state_ff <= S_PRE_RD;
               end
            end
            S_SC_RD: state_ff <= S_SC_DIG;
            S_SC_DIG: begin
               dig_ff   <= cur_dig;
               tup_ff   <= src_rdata;
               state_ff <= S_SC_WR;
            end
            S_SC_WR: begin
               if (idx_ff == loaded_ff - mrc_pkg::CNT_W'(1)) begin
                  // The scattered copy becomes the source of the next pass.
                  idx_ff     <= '0;
                  cur_sel_ff <= !cur_sel_ff;
                  if (pass_ff == '0) begin
                     reading_ff <= 1'b1;
                     rptr_ff    <= '0;
                     state_ff   <= S_IDLE;
                  end else begin
                     pass_ff  <= pass_ff - mrc_pkg::PASS_W'(1);
                     state_ff <= S_CLR;
                  end
               end else begin
                  idx_ff   <= idx_ff + mrc_pkg::CNT_W'(1);
                  state_ff <= S_SC_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept)
      else $error("item accepted while clustering");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= mrc_pkg::CNT_W'(mrc_pkg::MAX_TUPLES))
      else $error("loaded count beyond capacity");

   a_scatter_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SC_WR) |-> (cnt_rdata < loaded_ff))
      else $error("scatter position beyond loaded tuples");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_WAIT) |=> (rsp_valid_ff && rsp_ff.status == mrc_pkg::ST_OK))
      else $error("good read did not produce a result");

endmodule

// ----- rtl/mrc_ram.sv -----
module mrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
